FILE: rtl/ntv_pkg.sv
// ntv_pkg: shared types and constants for the numeric token validator.
// No dependencies; imported by numeric_token_validator_unit and its testbench.
package ntv_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 3;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [CharW-1:0] ChLowerE = 8'h65;
  localparam logic [CharW-1:0] ChUpperE = 8'h45;
  localparam logic [CharW-1:0] ChMinus  = 8'h2D;
  localparam logic [CharW-1:0] ChPlus   = 8'h2B;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;

  localparam logic [CountW-1:0] GroupLen = 3'd3;
  localparam logic [CountW-1:0] CountSat = 3'd4;

  localparam logic [CharW-1:0] DecSepRst = 8'd46;
  localparam logic [CharW-1:0] GrpSepRst = 8'd44;

  // register index, taken from paddr[2]
  localparam logic RegDecSep = 1'b0;
  localparam logic RegGrpSep = 1'b1;

  typedef enum logic [1:0] {
    PH_START      = 2'd0,
    PH_AFTER_SIGN = 2'd1,
    PH_BODY       = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic                seen_dec;
    logic                seen_exp;
    logic                seen_grp;
    logic [CountW-1:0]   grp_cnt;
    logic                exp_sign_pend;
    logic                failed;
  } tok_state_t;

  localparam tok_state_t TokStateRst = '{
    phase:         PH_START,
    seen_dec:      1'b0,
    seen_exp:      1'b0,
    seen_grp:      1'b0,
    grp_cnt:       '0,
    exp_sign_pend: 1'b0,
    failed:        1'b0
  };

endpackage

FILE: rtl/numeric_token_validator_unit.sv
// numeric_token_validator_unit: number syntax checker, one character per transaction.
// Depends on ntv_pkg (rtl/ntv_pkg.sv).
//
// Usage:
//   Input stream (s_axis_*): one character per transaction in tdata[7:0];
//   tlast marks the final character of a token. Tokens follow back to back.
//   Output stream (m_axis_*): one transaction per token, issued for the
//   character carrying tlast; tdata[0] = 1 when the whole token is a valid
//   number (optional sign, digits, grouping marks, decimal point, exponent).
//   APB port: register 0 at 0x0 is the decimal separator, register 1 at 0x4
//   the grouping separator (both 8 bits). Write only while the block is idle.
// Timing:
//   One character per clock when not stalled (see below). The verdict is
//   registered in the cycle after the last character is taken. The per-token
//   state update is a single combinational step ahead of the state register.
// Reset / stall:
//   Reset clears the token state and output valid, and loads separators
//   '.' and ','. While a verdict waits in the output register the input
//   still flows as long as the receiver takes it in the same cycle; if the
//   receiver stalls, s_axis_tready drops until the verdict is taken.
module numeric_token_validator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [ntv_pkg::CharW-1:0] s_axis_tdata,   // [7:0] char_code
  input  logic                      s_axis_tlast,   // is_last
  // output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [0] token_valid, [7:1] zero
  // APB configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ntv_pkg::AddrW-1:0] paddr,
  input  logic [ntv_pkg::DataW-1:0] pwdata,
  output logic [ntv_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import ntv_pkg::*;

  logic [CharW-1:0] dec_sep_q;
  logic [CharW-1:0] grp_sep_q;
  tok_state_t       st_q, st_d;
  logic             out_vld_q;
  logic             out_ok_q, out_ok_d;
  logic             in_acc;
  logic             cfg_wr;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_sep_q <= DecSepRst;
      grp_sep_q <= GrpSepRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegDecSep: dec_sep_q <= pwdata[CharW-1:0];
        RegGrpSep: grp_sep_q <= pwdata[CharW-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      RegDecSep: prdata[CharW-1:0] = dec_sep_q;
      RegGrpSep: prdata[CharW-1:0] = grp_sep_q;
      default:   ;
    endcase
  end

  // ---------------- handshake ----------------
  // output register frees up in the same cycle the receiver takes it
  assign s_axis_tready = ~out_vld_q | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // ---------------- per-character state update ----------------
  always_comb begin
    logic             is_sign;
    logic             is_digit;
    logic             is_exp;
    logic             at_start;
    logic [CharW-1:0] c;
    tok_state_t       nxt;

    c        = s_axis_tdata;
    is_sign  = (c == ChMinus) || (c == ChPlus);
    is_digit = (c >= ChZero) && (c <= ChNine);
    is_exp   = (c == ChLowerE) || (c == ChUpperE);
    at_start = (st_q.phase != PH_BODY);
    nxt      = st_q;
    out_ok_d = 1'b0;

    if (!nxt.failed) begin
      if (st_q.phase == PH_START && is_sign) begin
        nxt.phase = PH_AFTER_SIGN;
        if (s_axis_tlast) nxt.failed = 1'b1;          // lone sign
      end else if (st_q.exp_sign_pend && is_sign) begin
        nxt.exp_sign_pend = 1'b0;
        nxt.phase         = PH_BODY;
        if (s_axis_tlast) nxt.failed = 1'b1;          // exponent sign at end
      end else begin
        nxt.exp_sign_pend = 1'b0;
        nxt.phase         = PH_BODY;
        if (c == dec_sep_q) begin
          if (st_q.seen_dec || st_q.seen_exp) begin
            nxt.failed = 1'b1;
          end else begin
            nxt.seen_dec = 1'b1;
            nxt.grp_cnt  = '0;
          end
        end else if (c == grp_sep_q && !st_q.seen_dec && !st_q.seen_exp) begin
          if (st_q.seen_grp ? (st_q.grp_cnt != GroupLen)
                            : (st_q.grp_cnt == '0 || st_q.grp_cnt > GroupLen)) begin
            nxt.failed = 1'b1;
          end else begin
            nxt.seen_grp = 1'b1;
            nxt.grp_cnt  = '0;
          end
        end else if (is_exp) begin
          if (st_q.seen_exp || at_start ||
              (st_q.seen_grp && !st_q.seen_dec && st_q.grp_cnt != GroupLen)) begin
            nxt.failed = 1'b1;
          end else begin
            nxt.seen_exp      = 1'b1;
            nxt.seen_grp      = 1'b0;
            nxt.exp_sign_pend = 1'b1;
          end
        end else if (is_digit) begin
          if (st_q.grp_cnt < CountSat) nxt.grp_cnt = st_q.grp_cnt + 1'b1;
        end else begin
          nxt.failed = 1'b1;
        end
      end
    end

    if (s_axis_tlast) begin
      // open final group must be complete
      if (nxt.seen_grp && !nxt.seen_dec && !nxt.seen_exp && nxt.grp_cnt != GroupLen) begin
        nxt.failed = 1'b1;
      end
      out_ok_d = ~nxt.failed;
      nxt      = TokStateRst;
    end

    st_d = in_acc ? nxt : st_q;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= TokStateRst;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (in_acc && s_axis_tlast) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // verdict payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) out_ok_q <= out_ok_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_ok_q};

endmodule

FILE: tb/tb_numeric_token_validator_unit.sv
// Testbench for numeric_token_validator_unit: directed and random tokens, one char per transaction.
// Checks every verdict against a built-in scanner of the number syntax or a typed-in value.
// Depends on ntv_pkg and numeric_token_validator_unit (rtl/).
`timescale 1ns / 1ps

module tb_numeric_token_validator_unit;
  import ntv_pkg::*;

  // generous bound on the run: ~1100 chars in all
  localparam int CycleLimit      = 400000;
  // minimum characters sent per separator setting in the random part
  localparam int CharsPerSetting = 170;
  // verdict sits in the output register in the cycle after the last char
  localparam int DrainCycles     = 4;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [CharW-1:0]     s_axis_tdata  = '0;   // [7:0] char_code
  logic                 s_axis_tlast  = 1'b0; // is_last
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;         // [0] token_valid, [7:1] zero
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [AddrW-1:0]     paddr         = '0;
  logic [DataW-1:0]     pwdata        = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  numeric_token_validator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scanner: tracks the syntax state of the token in flight, using the TB's
  // own copy of both separator registers.
  // ---------------------------------------------------------------------------
  logic [CharW-1:0]  dec_sep = DecSepRst;
  logic [CharW-1:0]  grp_sep = GrpSepRst;

  phase_e            sc_phase;
  logic              sc_dec;      // decimal point taken
  logic              sc_exp;      // exponent letter taken
  logic              sc_grp;      // grouping mark taken in the mantissa
  logic [CountW-1:0] sc_cnt;      // digits since last separator, saturating
  logic              sc_esign;    // previous char was the exponent letter
  logic              sc_bad;      // token already failed, rest is ignored

  function automatic void scan_clear();
    sc_phase = PH_START;
    sc_dec   = 1'b0;
    sc_exp   = 1'b0;
    sc_grp   = 1'b0;
    sc_cnt   = '0;
    sc_esign = 1'b0;
    sc_bad   = 1'b0;
  endfunction

  // Advance the scanner by one char; the return value is the verdict and
  // only means something when last is set.
  function automatic logic scan_char(input logic [CharW-1:0] c, input logic last);
    logic sign;
    logic at_start;
    logic verdict;
    sign    = (c == ChPlus) || (c == ChMinus);
    verdict = 1'b0;
    if (!sc_bad) begin
      if (sc_phase == PH_START && sign) begin
        // leading sign; a lone sign is not a number
        sc_phase = PH_AFTER_SIGN;
        if (last) sc_bad = 1'b1;
      end else if (sc_esign && sign) begin
        // exponent sign; must not end the token
        sc_esign = 1'b0;
        sc_phase = PH_BODY;
        if (last) sc_bad = 1'b1;
      end else begin
        at_start = (sc_phase != PH_BODY);
        sc_esign = 1'b0;
        sc_phase = PH_BODY;
        // test order matters: decimal beats grouping beats exponent beats digit
        if (c == dec_sep) begin
          if (sc_dec || sc_exp) sc_bad = 1'b1;
          else begin
            sc_dec = 1'b1;
            sc_cnt = '0;
          end
        end else if (c == grp_sep && !sc_dec && !sc_exp) begin
          if (sc_grp ? (sc_cnt != GroupLen) : (sc_cnt < 1 || sc_cnt > GroupLen)) begin
            sc_bad = 1'b1;
          end else begin
            sc_grp = 1'b1;
            sc_cnt = '0;
          end
        end else if (c == ChLowerE || c == ChUpperE) begin
          if (sc_exp || at_start) sc_bad = 1'b1;
          else if (sc_grp && !sc_dec && sc_cnt != GroupLen) sc_bad = 1'b1;
          else begin
            sc_exp   = 1'b1;
            sc_grp   = 1'b0;
            sc_esign = 1'b1;
          end
        end else if (c >= ChZero && c <= ChNine) begin
          if (sc_cnt < CountSat) sc_cnt = sc_cnt + 1'b1;
        end else begin
          sc_bad = 1'b1;
        end
      end
    end
    if (last) begin
      // an open group at the end of a plain grouped integer must be full
      if (!sc_bad && sc_grp && !sc_dec && !sc_exp && sc_cnt != GroupLen) sc_bad = 1'b1;
      verdict = !sc_bad;
      scan_clear();
    end
    return verdict;
  endfunction

  // ---------------------------------------------------------------------------
  // Verdict checking
  // ---------------------------------------------------------------------------
  logic verdict_q[$];   // verdicts owed by the block, oldest first
  int   err_cnt   = 0;
  int   cycle_cnt = 0;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $error("token_valid: expected none, got %0b", m_axis_tdata[0]);
        err_cnt++;
      end else begin
        logic want;
        want = verdict_q.pop_front();
        if (m_axis_tdata[0] !== want) begin
          $error("token_valid: expected %0b, got %0b", want, m_axis_tdata[0]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("numeric_token_validator_unit verification failed");
      $finish;
    end
  end

  // Receiver: switches between always-ready, coin-flip and mostly-stalled
  // stretches of random length.
  int rx_mode = 0;
  int rx_left = 0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(16, 128);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them. tvalid stays
  // high from one transaction into the next unless a gap starts.
  // ---------------------------------------------------------------------------
  logic [CharW-1:0] tok_q[$];   // chars of the token being sent
  int               burst_left = 0;

  function automatic void tok_add(input logic [CharW-1:0] c);
    tok_q = {tok_q, c};
  endfunction

  task automatic send_char(input logic [CharW-1:0] c, input logic last, input int want);
    logic v;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    v = scan_char(c, last);
    if (last) verdict_q = {verdict_q, ((want < 0) ? v : want[0])};
  endtask

  // want < 0: take the scanner's verdict; else the typed-in one
  task automatic send_token(input int want);
    for (int i = 0; i < tok_q.size(); i++) begin
      send_char(tok_q[i], i == tok_q.size() - 1, want);
    end
  endtask

  // drop tvalid and let every owed verdict come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random token builder
  // ---------------------------------------------------------------------------
  function automatic void add_digits(input int n);
    repeat (n) tok_add(8'(ChZero + $urandom_range(0, 9)));
  endfunction

  function automatic logic [CharW-1:0] pick_char();
    case ($urandom_range(0, 7))
      0, 1:    return 8'(ChZero + $urandom_range(0, 9));
      2:       return ChPlus;
      3:       return ChMinus;
      4:       return ChLowerE;
      5:       return ChUpperE;
      6:       return dec_sep;
      default: return grp_sep;
    endcase
  endfunction

  function automatic void build_token();
    int kind;
    int d;
    kind = $urandom_range(0, 9);
    tok_q.delete();
    if (kind <= 6) begin
      // mostly well formed, with the occasional off-by-one group or stray char
      if ($urandom_range(0, 2) == 0) tok_add($urandom_range(0, 1) ? ChPlus : ChMinus);
      if ($urandom_range(0, 2) == 0) begin
        d = $urandom_range(0, 7);
        add_digits((d < 6) ? (d % 3 + 1) : ((d == 6) ? 0 : 4));
        repeat ($urandom_range(1, 3)) begin
          tok_add(grp_sep);
          add_digits(($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 3);
        end
      end else begin
        add_digits($urandom_range(0, 6));
      end
      if ($urandom_range(0, 1)) begin
        tok_add(dec_sep);
        add_digits($urandom_range(0, 4));
      end
      if ($urandom_range(0, 2) == 0) begin
        tok_add($urandom_range(0, 1) ? ChLowerE : ChUpperE);
        if ($urandom_range(0, 1)) tok_add($urandom_range(0, 1) ? ChPlus : ChMinus);
        add_digits($urandom_range(0, 3));
      end
      if (tok_q.size() == 0) add_digits(1);
      if ($urandom_range(0, 9) == 0) begin
        tok_q[$urandom_range(0, tok_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end else if (kind <= 8) begin
      // syntax chars in random order
      repeat ($urandom_range(1, 6)) tok_add(pick_char());
    end else begin
      // any byte at all
      repeat ($urandom_range(1, 4)) tok_add(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // APB access
  // ---------------------------------------------------------------------------
  task automatic apb_xfer(input logic wr, input logic [AddrW-1:0] addr,
                          input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    // back to idle (psel low) before the next setup phase
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic idx, input logic [CharW-1:0] want, input string name);
    logic [DataW-1:0] rd;
    apb_xfer(1'b0, {idx, 2'b00}, '0, rd);
    if (rd !== DataW'(want)) begin
      $error("%s: expected %0h, got %0h", name, want, rd);
      err_cnt++;
    end
  endtask

  task automatic set_separators(input logic [CharW-1:0] dec, input logic [CharW-1:0] grp);
    logic [DataW-1:0] rd;
    apb_xfer(1'b1, {RegDecSep, 2'b00}, DataW'(dec), rd);
    apb_xfer(1'b1, {RegGrpSep, 2'b00}, DataW'(grp), rd);
    dec_sep = dec;
    grp_sep = grp;
    check_reg(RegDecSep, dec, "decimal_separator");
    check_reg(RegGrpSep, grp, "grouping_separator");
  endtask

  // ---------------------------------------------------------------------------
  // Directed tokens, default separators. txt empty: one raw byte instead.
  // want -1: verdict from the scanner.
  // ---------------------------------------------------------------------------
  typedef struct {
    string            txt;
    logic [CharW-1:0] raw;
    int               want;
  } dir_row_t;

  dir_row_t dir_rows[10] = '{
    '{"-",       8'h00,  0},   // lone sign
    '{"+E",      8'h00,  0},   // exponent right after the leading sign
    '{"1e+",     8'h00,  0},   // exponent sign ends the token
    '{"1e",      8'h00,  1},   // bare exponent letter is accepted
    '{".",       8'h00,  1},   // bare decimal point is accepted
    '{"12,34",   8'h00,  0},   // short closing group
    '{"",        8'h00,  0},   // lowest byte
    '{"",        8'hFF,  0},   // highest byte
    '{"1,234.5", 8'h00, -1},
    '{"9e-7",    8'h00, -1}
  };

  // separator settings for the random part: default, swapped, extremes,
  // both equal (decimal wins), and codes that steal sign and digit chars
  logic [CharW-1:0] plan_dec[6] = '{DecSepRst, GrpSepRst, 8'h00, 8'hFF, DecSepRst, ChPlus};
  logic [CharW-1:0] plan_grp[6] = '{GrpSepRst, DecSepRst, 8'hFF, 8'h00, DecSepRst, ChZero};

  initial begin
    int sent;
    scan_clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_reg(RegDecSep, DecSepRst, "decimal_separator");
    check_reg(RegGrpSep, GrpSepRst, "grouping_separator");

    foreach (dir_rows[r]) begin
      tok_q.delete();
      if (dir_rows[r].txt.len() == 0) tok_add(dir_rows[r].raw);
      else for (int i = 0; i < dir_rows[r].txt.len(); i++) tok_add(dir_rows[r].txt[i]);
      send_token(dir_rows[r].want);
    end

    foreach (plan_dec[p]) begin
      // registers change only with the pipe empty
      wait_idle();
      set_separators(plan_dec[p], plan_grp[p]);
      sent = 0;
      while (sent < CharsPerSetting) begin
        build_token();
        send_token(-1);
        sent += tok_q.size();
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("numeric_token_validator_unit verification clean");
    end else begin
      $display("numeric_token_validator_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: numeric_token_validator_unit.f
rtl/ntv_pkg.sv
rtl/numeric_token_validator_unit.sv
tb/tb_numeric_token_validator_unit.sv
